>>> rtl/ipmb_pkg.sv
// Shared types and constants for the IPv4-to-MAC binding checker.
package ipmb_pkg;

	localparam logic [15:0] ETYPE_IPV4          = 16'h0800;
	localparam int          MAC_BYTES           = 6;
	localparam int          MAC_W               = 8 * MAC_BYTES;
	localparam int          IP_W                = 32;
	localparam int          CNT_W               = 32;
	localparam int          TABLE_DEPTH_DEFAULT = 64;

	typedef enum logic [1:0] {
		MODE_PACKET = 2'd0,
		MODE_ADD    = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		V_MATCH    = 3'd0,
		V_MISMATCH = 3'd1,
		V_NOTFOUND = 3'd2,
		V_UNKNOWN  = 3'd3,
		V_NONE     = 3'd4
	} verdict_t;

	typedef enum logic [1:0] {
		S_OK   = 2'd0,
		S_DUP  = 2'd1,
		S_FULL = 2'd2,
		S_NONE = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic             header_complete;
		logic [15:0]      eth_type;
		logic [IP_W-1:0]  src_ip;
		logic [MAC_W-1:0] src_mac;
	} item_t;

	typedef struct packed {
		logic [2:0]       verdict;
		logic [1:0]       table_status;
		logic [CNT_W-1:0] count_in;
		logic [CNT_W-1:0] count_match;
		logic [CNT_W-1:0] count_mismatch;
		logic [CNT_W-1:0] count_notfound;
		logic [CNT_W-1:0] count_unknown;
		logic [CNT_W-1:0] count_out;
	} result_t;

endpackage

>>> rtl/ipmb_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
interface ipmb_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/ip_mac_binding_check.sv
// Top level: IPv4-to-MAC binding table with per-header classification and counters.
// An accepted item is held in the input register, then its result goes to the output register.
// Throughput: one item per cycle unless stalled; whole table compared in parallel against
// the registered item and updated at the same edge that loads the result register.
// Reset: binding table empty (valid bits cleared), all counters zero, no clear sweep.
module ip_mac_binding_check
	import ipmb_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
	input logic              clk,
	input logic              arst_n,
	ipmb_stream_if.sink      item,
	ipmb_stream_if.source    result
);

	item_t                   item_s1;
	logic                    valid_s1;
	logic                    res_valid_q;
	logic [2:0]              verdict_q;
	logic [1:0]              status_q;

	logic [TABLE_DEPTH-1:0]  entry_valid_q;
	logic [IP_W-1:0]         entry_ip_q  [TABLE_DEPTH];
	logic [MAC_W-1:0]        entry_mac_q [TABLE_DEPTH];

	logic [CNT_W-1:0]        cnt_in_q;
	logic [CNT_W-1:0]        cnt_match_q;
	logic [CNT_W-1:0]        cnt_mismatch_q;
	logic [CNT_W-1:0]        cnt_notfound_q;
	logic [CNT_W-1:0]        cnt_unknown_q;

	logic                    advance;
	logic [TABLE_DEPTH-1:0]  ip_hit;
	logic [TABLE_DEPTH-1:0]  mac_eq;
	logic [TABLE_DEPTH-1:0]  free;
	logic [TABLE_DEPTH-1:0]  free_lo;
	logic                    any_hit;
	logic                    mac_ok;
	logic                    full;
	logic                    is_ipv4;
	logic                    do_add;
	logic [2:0]              verdict_d;
	logic [1:0]              status_d;

	// Move the registered item into the result register when that slot frees up.
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	// Parallel compare of every entry against the registered item.
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			ip_hit[i] = entry_valid_q[i] && (entry_ip_q[i] == item_s1.src_ip);
			mac_eq[i] = entry_mac_q[i] == item_s1.src_mac;
		end
	end

	assign any_hit = |ip_hit;
	// IPs are unique in the table, so at most one hit feeds this.
	assign mac_ok  = |(ip_hit & mac_eq);
	assign full    = &entry_valid_q;
	assign free    = ~entry_valid_q;
	// Isolate the lowest free entry.
	assign free_lo = free & (~free + TABLE_DEPTH'(1));
	assign is_ipv4 = item_s1.header_complete && (item_s1.eth_type == ETYPE_IPV4);

	always_comb begin
		verdict_d = V_NONE;
		status_d  = S_NONE;
		do_add    = 1'b0;
		unique case (item_s1.mode)
			MODE_PACKET: begin
				if (!is_ipv4) begin
					verdict_d = V_UNKNOWN;
				end else if (!any_hit) begin
					verdict_d = V_NOTFOUND;
				end else if (mac_ok) begin
					verdict_d = V_MATCH;
				end else begin
					verdict_d = V_MISMATCH;
				end
			end
			MODE_ADD: begin
				if (any_hit) begin
					status_d = S_DUP;
				end else if (full) begin
					status_d = S_FULL;
				end else begin
					status_d = S_OK;
					do_add   = 1'b1;
				end
			end
			MODE_CLEAR: begin
				status_d = S_NONE;
			end
			default: begin
				status_d = S_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (advance) begin
			if (item_s1.mode == MODE_CLEAR) begin
				entry_valid_q <= '0;
			end else if (do_add) begin
				entry_valid_q <= entry_valid_q | free_lo;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (advance && do_add && free_lo[i]) begin
				entry_ip_q[i]  <= item_s1.src_ip;
				entry_mac_q[i] <= item_s1.src_mac;
			end
		end
	end

	// Counters change only when a result is loaded, so they always match the
	// result on display.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_in_q       <= '0;
			cnt_match_q    <= '0;
			cnt_mismatch_q <= '0;
			cnt_notfound_q <= '0;
			cnt_unknown_q  <= '0;
		end else if (advance && (item_s1.mode == MODE_PACKET)) begin
			cnt_in_q <= cnt_in_q + CNT_W'(1);
			case (verdict_d)
				V_MATCH:    cnt_match_q    <= cnt_match_q + CNT_W'(1);
				V_MISMATCH: cnt_mismatch_q <= cnt_mismatch_q + CNT_W'(1);
				V_NOTFOUND: cnt_notfound_q <= cnt_notfound_q + CNT_W'(1);
				V_UNKNOWN:  cnt_unknown_q  <= cnt_unknown_q + CNT_W'(1);
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_q <= verdict_d;
			status_q  <= status_d;
		end
	end

	assign result.valid               = res_valid_q;
	assign result.data.verdict        = verdict_q;
	assign result.data.table_status   = status_q;
	assign result.data.count_in       = cnt_in_q;
	assign result.data.count_match    = cnt_match_q;
	assign result.data.count_mismatch = cnt_mismatch_q;
	assign result.data.count_notfound = cnt_notfound_q;
	assign result.data.count_unknown  = cnt_unknown_q;
	// Every packet bumps the input count and exactly one class count.
	assign result.data.count_out      = cnt_in_q;

	a_sum_equals_in: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_in_q == CNT_W'(cnt_match_q + cnt_mismatch_q + cnt_notfound_q + cnt_unknown_q))
		else $error("class counters do not add up to the input count");

	a_unique_ip: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(ip_hit))
		else $error("more than one table entry holds the same IP");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (item_s1.mode == MODE_CLEAR) |=> entry_valid_q == '0)
		else $error("table not empty after clear");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && do_add |=>
			$countones(entry_valid_q) == $past($countones(entry_valid_q)) + 1)
		else $error("successful add did not take exactly one entry");

	a_refused_add_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (item_s1.mode == MODE_ADD) && !do_add |=> $stable(entry_valid_q))
		else $error("refused add changed the table");

endmodule
